// File: rtl/act_pkg.sv
`timescale 1ns / 1ps
package act_pkg;
  localparam int MaxEntries = 256;
  localparam int KeyW = 64;
  localparam int RoomW = 64;
  localparam int KindW = 16;
  localparam int ExpW = 27;
  localparam int VerW = 32;
  localparam int EntryW = KeyW + RoomW + KindW + ExpW;

  localparam logic [2:0] CmdAdd = 3'd0;
  localparam logic [2:0] CmdDelCard = 3'd1;
  localparam logic [2:0] CmdDelRoom = 3'd2;
  localparam logic [2:0] CmdCheck = 3'd3;
  localparam logic [2:0] CmdClear = 3'd4;
  localparam logic [2:0] CmdSyncStart = 3'd5;
  localparam logic [2:0] CmdSyncAppend = 3'd6;
  localparam logic [2:0] CmdSyncFinish = 3'd7;

  localparam logic [1:0] StatOk = 2'd0;
  localparam logic [1:0] StatMiss = 2'd1;
  localparam logic [1:0] StatFull = 2'd2;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [RoomW-1:0] room;
    logic [KindW-1:0] kind;
    logic [ExpW-1:0] exp;
  } entry_t;
endpackage

// File: rtl/access_card_table.sv
`timescale 1ns / 1ps
// Add, check and delete scan one entry per cycle through a registered-read memory,
// stopping at a hit or, on a miss, after the last used entry. A delete then shifts
// each later entry down one place, read in SShRd and written in SShWr. Clear and
// the sync commands go straight from idle to the done state.
// One word is processed at a time; the result register frees the input side.
// Reset (synchronous, active high) empties the table and zeroes the version.
module access_card_table #(
  parameter int MAX_ENTRIES = act_pkg::MaxEntries
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [2:0] command,
  input  logic [act_pkg::KeyW-1:0] card_number,
  input  logic [act_pkg::RoomW-1:0] room_number,
  input  logic [act_pkg::KindW-1:0] card_kind,
  input  logic [act_pkg::ExpW-1:0] expiry,
  input  logic [act_pkg::VerW-1:0] sync_version,
  output logic out_valid,
  input  logic out_stall,
  output logic [1:0] status,
  output logic newly_added,
  output logic [act_pkg::RoomW-1:0] found_room,
  output logic [act_pkg::KindW-1:0] found_kind,
  output logic [act_pkg::ExpW-1:0] found_expiry,
  output logic [act_pkg::VerW-1:0] table_version,
  output logic [$clog2(MAX_ENTRIES+1)-1:0] entry_total
);
  import act_pkg::*;

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] Full = CW'(MAX_ENTRIES);

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SScan = 3'd1;
  localparam logic [2:0] SCmp = 3'd2;
  localparam logic [2:0] SShRd = 3'd3;
  localparam logic [2:0] SShWr = 3'd4;
  localparam logic [2:0] SDone = 3'd5;

  entry_t mem [MAX_ENTRIES];
  entry_t rd_data;
  logic [AW-1:0] rd_addr, wr_addr;
  logic wr_en;
  entry_t wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  logic [2:0] state;
  logic [2:0] cmd;
  entry_t cur;
  logic [CW-1:0] used;
  logic [VerW-1:0] version;
  logic [CW-1:0] idx;
  logic [CW-1:0] cidx;

  logic [1:0] r_status;
  logic r_added;
  entry_t r_found;

  logic [1:0] res_status;
  logic res_added;
  entry_t res_found;
  logic [VerW-1:0] res_version;
  logic [CW-1:0] res_used;

  assign in_stall = (state != SIdle);
  assign status = res_status;
  assign newly_added = res_added;
  assign found_room = res_found.room;
  assign found_kind = res_found.kind;
  assign found_expiry = res_found.exp;
  assign table_version = res_version;
  assign entry_total = res_used;

  logic hit;
  assign hit = (rd_data.key == cur.key) &&
               ((cmd != CmdDelRoom) || (rd_data.room == cur.room));

  always_comb begin
    rd_addr = idx[AW-1:0];
    wr_en = 1'b0;
    wr_addr = idx[AW-1:0];
    wr_data = cur;
    if (state == SShWr) begin
      wr_en = 1'b1;
      wr_addr = AW'(idx - 1'b1);
      wr_data = rd_data;
    end else if (state == SCmp && cidx == used) begin
      wr_en = (cmd == CmdAdd) && (used != Full);
      wr_addr = used[AW-1:0];
    end else if (state == SCmp && hit && cmd == CmdAdd) begin
      wr_en = 1'b1;
      wr_addr = cidx[AW-1:0];
    end else if (state == SIdle) begin
      wr_en = in_valid && !in_stall && command == CmdSyncAppend && used != Full;
      wr_addr = used[AW-1:0];
      wr_data = '{card_number, room_number, card_kind, expiry};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SIdle;
      out_valid <= 1'b0;
      used <= '0;
      version <= '0;
    end else begin
      if (out_valid && !out_stall && state != SDone) begin
        out_valid <= 1'b0;
      end
      case (state)
        SIdle: begin
          if (in_valid && !in_stall) begin
            cmd <= command;
            cur <= '{card_number, room_number, card_kind, expiry};
            idx <= '0;
            cidx <= '0;
            r_status <= StatOk;
            r_added <= 1'b0;
            r_found <= '0;
            state <= SDone;
            case (command)
              CmdClear: begin
                used <= '0;
                version <= version + 1'b1;
              end
              CmdSyncStart: begin
                used <= '0;
                if (sync_version != '0) begin
                  version <= sync_version - 1'b1;
                end
              end
              CmdSyncAppend: begin
                if (used == Full) begin
                  r_status <= StatFull;
                end else begin
                  used <= used + 1'b1;
                  r_added <= 1'b1;
                end
              end
              CmdSyncFinish: version <= version + 1'b1;
              default: state <= SScan;
            endcase
          end
        end
        SScan: begin
          // Read of entry idx issued this cycle; compare next cycle.
          cidx <= idx;
          idx <= idx + 1'b1;
          state <= SCmp;
        end
        SCmp: begin
          if (cidx == used) begin
            state <= SDone;
            if (cmd == CmdAdd) begin
              if (used == Full) begin
                r_status <= StatFull;
              end else begin
                used <= used + 1'b1;
                r_added <= 1'b1;
                version <= version + 1'b1;
              end
            end else begin
              r_status <= StatMiss;
            end
          end else if (hit) begin
            case (cmd)
              CmdAdd: begin
                version <= version + 1'b1;
                state <= SDone;
              end
              CmdCheck: begin
                r_found <= rd_data;
                state <= SDone;
              end
              default: begin
                // idx already points at the entry after the hit.
                state <= SShRd;
              end
            endcase
          end else begin
            cidx <= idx;
            idx <= idx + 1'b1;
          end
        end
        SShRd: begin
          if (idx >= used) begin
            used <= used - 1'b1;
            version <= version + 1'b1;
            state <= SDone;
          end else begin
            state <= SShWr;
          end
        end
        SShWr: begin
          idx <= idx + 1'b1;
          state <= SShRd;
        end
        SDone: begin
          // The new result word waits here until the previous one is taken.
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            res_status <= r_status;
            res_added <= r_added;
            res_found <= r_found;
            res_version <= version;
            res_used <= used;
            state <= SIdle;
          end
        end
        default: state <= SIdle;
      endcase
    end
  end
endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import act_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] command = CmdCheck;
  logic [KeyW-1:0] card_number = '0;
  logic [RoomW-1:0] room_number = '0;
  logic [KindW-1:0] card_kind = '0;
  logic [ExpW-1:0] expiry = '0;
  logic [VerW-1:0] sync_version = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] status;
  logic newly_added;
  logic [RoomW-1:0] found_room;
  logic [KindW-1:0] found_kind;
  logic [ExpW-1:0] found_expiry;
  logic [VerW-1:0] table_version;
  logic [8:0] entry_total;

  access_card_table u_top (.*);

  typedef struct packed {
    logic [1:0] status;
    logic added;
    logic [RoomW-1:0] room;
    logic [KindW-1:0] kind;
    logic [ExpW-1:0] exp;
    logic [VerW-1:0] version;
    logic [8:0] total;
  } reply_t;

  class card_scoreboard;
    entry_t rows[$];
    logic [VerW-1:0] version;
    reply_t pending[$];
    int errors;
    int shown;

    function new();
      version = '0;
      errors = 0;
      shown = 0;
    endfunction

    function int find_row(logic [KeyW-1:0] key, bit with_room, logic [RoomW-1:0] room);
      for (int i = 0; i < rows.size(); i++)
        if (rows[i].key == key && (!with_room || rows[i].room == room)) return i;
      return -1;
    endfunction

    function void note_command(logic [2:0] cmd, logic [KeyW-1:0] key,
                               logic [RoomW-1:0] room, logic [KindW-1:0] kind,
                               logic [ExpW-1:0] exp, logic [VerW-1:0] sver);
      reply_t r;
      entry_t e;
      int i;
      r = '0;
      e.key = key;
      e.room = room;
      e.kind = kind;
      e.exp = exp;
      case (cmd)
        CmdAdd: begin
          i = find_row(key, 1'b0, '0);
          if (i >= 0) begin
            rows[i] = e;
            version++;
          end else if (rows.size() < MaxEntries) begin
            rows.push_back(e);
            r.added = 1'b1;
            version++;
          end else r.status = StatFull;
        end
        CmdDelCard, CmdDelRoom: begin
          i = find_row(key, cmd == CmdDelRoom, room);
          if (i >= 0) begin
            rows.delete(i);
            version++;
          end else r.status = StatMiss;
        end
        CmdCheck: begin
          i = find_row(key, 1'b0, '0);
          if (i >= 0) begin
            r.room = rows[i].room;
            r.kind = rows[i].kind;
            r.exp = rows[i].exp;
          end else r.status = StatMiss;
        end
        CmdClear: begin
          rows.delete();
          version++;
        end
        CmdSyncStart: begin
          rows.delete();
          if (sver != 0) version = sver - 1;
        end
        CmdSyncAppend: begin
          if (rows.size() < MaxEntries) begin
            rows.push_back(e);
            r.added = 1'b1;
          end else r.status = StatFull;
        end
        default: version++;
      endcase
      r.version = version;
      r.total = 9'(rows.size());
      pending.push_back(r);
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (pending.size() == 0) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("unexpected result word %h", got);
        end
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("mismatch: status %0d/%0d added %0d/%0d room %h/%h kind %h/%h",
                   want.status, got.status, want.added, got.added,
                   want.room, got.room, want.kind, got.kind);
          $display("  expiry %0d/%0d version %h/%h total %0d/%0d",
                   want.exp, got.exp, want.version, got.version, want.total, got.total);
        end
      end
    endfunction
  endclass

  card_scoreboard board = new();
  logic [KeyW-1:0] key_pool[8];
  logic [RoomW-1:0] room_pool[4];
  int cycles = 0;
  bit calm = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 10000000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_reply({status, newly_added, found_room, found_kind, found_expiry,
                         table_version, entry_total});
    out_stall <= (!calm && $urandom_range(99) < 22);
  end

  // in_valid stays high after an accepted word unless the next word idles first.
  task automatic send_word(logic [2:0] cmd, logic [KeyW-1:0] key, logic [RoomW-1:0] room,
                           logic [KindW-1:0] kind, logic [ExpW-1:0] exp,
                           logic [VerW-1:0] sver);
    while (!calm && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    card_number <= key;
    room_number <= room;
    card_kind <= kind;
    expiry <= exp;
    sync_version <= sver;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_command(cmd, key, room, kind, exp, sver);
  endtask

  task automatic send_random(int fill_bias);
    logic [2:0] cmd;
    logic [KeyW-1:0] key;
    logic [RoomW-1:0] room;
    int pick;
    pick = $urandom_range(99);
    if (pick < fill_bias) cmd = CmdAdd;
    else if (pick < fill_bias + 8) cmd = CmdSyncAppend;
    else if (pick < 97) cmd = 3'($urandom_range(3, 1));
    else cmd = 3'($urandom_range(7, 4));
    key = ($urandom_range(9) < 8) ? key_pool[3'($urandom_range(7))] : {$urandom, $urandom};
    room = ($urandom_range(3) < 3) ? room_pool[2'($urandom_range(3))] : {$urandom, $urandom};
    send_word(cmd, key, room, 16'($urandom), 27'($urandom_range(99999999)),
              ($urandom_range(3) == 0) ? 32'd0 : $urandom);
  endtask

  initial begin
    for (int i = 0; i < 8; i++) key_pool[i] = {$urandom, $urandom};
    for (int i = 0; i < 4; i++) room_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;
    room_pool[0] = '0;
    room_pool[1] = '1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed words: misses on an empty table, each command, field extremes.
    send_word(CmdCheck, '0, '0, '0, '0, '0);
    send_word(CmdDelCard, '1, '0, '0, '0, '0);
    send_word(CmdAdd, '0, '1, '1, 27'd99999999, '1);
    send_word(CmdAdd, '1, '0, '0, '0, '0);
    send_word(CmdAdd, '0, 64'h5, 16'h7, 27'd20240101, '0);
    send_word(CmdCheck, '0, '0, '0, '0, '0);
    send_word(CmdCheck, '1, '0, '0, '0, '0);
    send_word(CmdDelRoom, '0, '1, '0, '0, '0);
    send_word(CmdDelRoom, '0, 64'h5, '0, '0, '0);
    send_word(CmdClear, '0, '0, '0, '0, '0);
    send_word(CmdSyncStart, '0, '0, '0, '0, 32'd0);
    send_word(CmdSyncStart, '0, '0, '0, '0, 32'd1);
    send_word(CmdSyncAppend, 64'h9, 64'h1, 16'h2, 27'd3, '0);
    send_word(CmdSyncAppend, 64'h9, 64'h4, 16'h5, 27'd6, '0);
    send_word(CmdDelCard, 64'h9, '0, '0, '0, '0);
    send_word(CmdCheck, 64'h9, '0, '0, '0, '0);
    send_word(CmdSyncFinish, '0, '0, '0, '0, '0);
    send_word(CmdSyncStart, '0, '0, '0, '0, '1);
    send_word(CmdSyncFinish, '0, '0, '0, '0, '0);
    send_word(CmdSyncFinish, '0, '0, '0, '0, '0);
    // Fill the table to see the full status, then delete from the front.
    for (int i = 0; i < 256; i++)
      send_word(CmdSyncAppend, 64'(i), ~64'(i), 16'(i), 27'(i), '0);
    send_word(CmdSyncAppend, '1, '0, '0, '0, '0);
    send_word(CmdAdd, 64'h1000, '0, '0, '0, '0);
    send_word(CmdAdd, 64'h5, '1, '1, '1, '0);
    send_word(CmdDelCard, 64'h0, '0, '0, '0, '0);
    send_word(CmdCheck, 64'hff, '0, '0, '0, '0);
    send_word(CmdClear, '0, '0, '0, '0, '0);
    for (int n = 0; n < 820; n++) begin
      calm = (n >= 400 && n < 550);
      send_random((n % 300 < 150) ? 45 : 25);
    end
    calm = 1'b0;
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (board.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

// File: files.f
rtl/act_pkg.sv
rtl/access_card_table.sv
tb/sv/tb_top.sv
